FILE: hdl/ihct_pkg.sv
// Shared types and constants for the in-flight / hold credit tracker.
// No dependencies; the other design files of the block import it, except ihct_check.
`timescale 1ns / 1ps

package ihct_pkg;

    localparam int TARGETS_DEF    = 16;
    localparam int VALUE_BITS_DEF = 48;

    localparam int FIELD_W = 48;
    localparam int TGT_W   = 4;
    localparam int OPC_W   = 3;

    localparam logic [OPC_W-1:0] OPC_QUERY   = 3'd0;
    localparam logic [OPC_W-1:0] OPC_ADD     = 3'd1;
    localparam logic [OPC_W-1:0] OPC_SUB     = 3'd2;
    localparam logic [OPC_W-1:0] OPC_HOLD    = 3'd3;
    localparam logic [OPC_W-1:0] OPC_RELEASE = 3'd4;
    localparam logic [OPC_W-1:0] OPC_REPORT  = 3'd5;
    localparam logic [OPC_W-1:0] OPC_SCAN    = 3'd6;

    localparam logic [FIELD_W-1:0] TTL_RESET = 48'd60000;

    // Depth of the queue between the front and back parts.
    localparam int Q_DEPTH = 2;

    // Work class decided by the front part.
    typedef enum logic [2:0] {
        K_QUERY,
        K_ADD,
        K_SUB,
        K_HOLD,
        K_RELEASE,
        K_REPORT,
        K_SCAN,
        K_NULL
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TGT_W-1:0]   target;
        logic [FIELD_W-1:0] amount;
        logic [FIELD_W-1:0] now;
        logic [FIELD_W-1:0] used;
    } t_item;

endpackage

FILE: hdl/inflight_hold_credit_tracker.sv
// Per-target in-flight and hold credit tracker: top level.
// Depends on ihct_pkg, ihct_front, ihct_queue and ihct_back.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Every command except the expiry scan
// goes through the back end as a record read from the record memory (one
// write port, one registered read port), then an update and result, and gives
// one result with o_last set. The expiry scan walks the memory one record per
// cycle, giving one result per expired hold followed by a closing result.
// Each result is shown for exactly one cycle with o_strobe high and cannot be
// stalled by the receiver. i_cfg_we writes the hold TTL; write it only while
// no command is pending.

module inflight_hold_credit_tracker #(
    parameter int TARGETS    = ihct_pkg::TARGETS_DEF,
    parameter int VALUE_BITS = ihct_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ihct_pkg::OPC_W-1:0]    i_opcode,
    input  logic [ihct_pkg::TGT_W-1:0]    i_target,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_amount_bytes,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_time_ms,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_used_memory,
    input  logic                          i_cfg_we,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_cfg_wdata,
    output logic                          o_strobe,
    output logic [ihct_pkg::TGT_W-1:0]    o_result_target,
    output logic [ihct_pkg::FIELD_W-1:0]  o_inflight_now,
    output logic [ihct_pkg::FIELD_W-1:0]  o_held_now,
    output logic [ihct_pkg::FIELD_W-1:0]  o_hold_start_ms,
    output logic [ihct_pkg::FIELD_W-1:0]  o_min_used_now,
    output logic                          o_flag,
    output logic                          o_last
);
    import ihct_pkg::*;

    logic                  q_full, q_empty, q_push, q_pop;
    t_item                 q_in, q_out;
    logic [VALUE_BITS-1:0] r_ttl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= VALUE_BITS'(TTL_RESET);
        end else if (i_cfg_we) begin
            r_ttl <= VALUE_BITS'(i_cfg_wdata);
        end
    end

    assign busy = q_full;

    ihct_front #(
        .TARGETS (TARGETS)
    ) u_front (
        .i_start        (start),
        .i_q_full       (q_full),
        .i_opcode       (i_opcode),
        .i_target       (i_target),
        .i_amount_bytes (i_amount_bytes),
        .i_time_ms      (i_time_ms),
        .i_used_memory  (i_used_memory),
        .o_push         (q_push),
        .o_item         (q_in)
    );

    ihct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    ihct_back #(
        .TARGETS    (TARGETS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (q_out),
        .i_empty         (q_empty),
        .i_ttl           (r_ttl),
        .o_pop           (q_pop),
        .o_strobe        (o_strobe),
        .o_result_target (o_result_target),
        .o_inflight_now  (o_inflight_now),
        .o_held_now      (o_held_now),
        .o_hold_start_ms (o_hold_start_ms),
        .o_min_used_now  (o_min_used_now),
        .o_flag          (o_flag),
        .o_last          (o_last)
    );

endmodule

FILE: hdl/ihct_front.sv
// Front part: takes a command transaction and classifies it for the back part.
// Depends on ihct_pkg.
`timescale 1ns / 1ps

module ihct_front #(
    parameter int TARGETS = ihct_pkg::TARGETS_DEF
) (
    input  logic                          i_start,
    input  logic                          i_q_full,
    input  logic [ihct_pkg::OPC_W-1:0]    i_opcode,
    input  logic [ihct_pkg::TGT_W-1:0]    i_target,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_amount_bytes,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_time_ms,
    input  logic [ihct_pkg::FIELD_W-1:0]  i_used_memory,
    output logic                          o_push,
    output ihct_pkg::t_item               o_item
);
    import ihct_pkg::*;

    logic  in_range;
    t_kind kind;

    always_comb begin
        in_range = int'(i_target) < TARGETS;
        kind     = K_QUERY;
        // A scan ignores the target; any other op on an absent index leaves the records unchanged and reports zeros.
        priority if (i_opcode == OPC_SCAN) begin
            kind = K_SCAN;
        end else if (!in_range) begin
            kind = K_NULL;
        end else begin
            unique case (i_opcode)
                OPC_QUERY:   kind = K_QUERY;
                OPC_ADD:     kind = K_ADD;
                OPC_SUB:     kind = K_SUB;
                OPC_HOLD:    kind = K_HOLD;
                OPC_RELEASE: kind = K_RELEASE;
                OPC_REPORT:  kind = K_REPORT;
                default:     kind = K_QUERY;
            endcase
        end
    end

    assign o_push        = i_start && !i_q_full;
    assign o_item.kind   = kind;
    assign o_item.target = i_target;
    assign o_item.amount = i_amount_bytes;
    assign o_item.now    = i_time_ms;
    assign o_item.used   = i_used_memory;

endmodule

FILE: hdl/ihct_queue.sv
// Short FIFO of classified transactions between the front and back parts.
// Depends on ihct_pkg.
`timescale 1ns / 1ps

module ihct_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ihct_pkg::t_item i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output ihct_pkg::t_item o_data
);
    import ihct_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_item          r_mem [Q_DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [AW:0]    r_count, n_count;

    assign o_full  = r_count == (AW+1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(Q_DEPTH-1)) ? '0 : r_wptr + AW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(Q_DEPTH-1)) ? '0 : r_rptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: hdl/ihct_back.sv
// Back part: record memory, read-modify-write engine, expiry scan, result register.
// Depends on ihct_pkg; fed by ihct_queue.
`timescale 1ns / 1ps

module ihct_back #(
    parameter int TARGETS    = ihct_pkg::TARGETS_DEF,
    parameter int VALUE_BITS = ihct_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ihct_pkg::t_item               i_item,
    input  logic                          i_empty,
    input  logic [VALUE_BITS-1:0]         i_ttl,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [ihct_pkg::TGT_W-1:0]    o_result_target,
    output logic [ihct_pkg::FIELD_W-1:0]  o_inflight_now,
    output logic [ihct_pkg::FIELD_W-1:0]  o_held_now,
    output logic [ihct_pkg::FIELD_W-1:0]  o_hold_start_ms,
    output logic [ihct_pkg::FIELD_W-1:0]  o_min_used_now,
    output logic                          o_flag,
    output logic                          o_last
);
    import ihct_pkg::*;

    localparam int IW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    localparam int VB = VALUE_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CLOSE = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    t_item          r_cur, n_cur;
    logic [IW-1:0]  r_idx, n_idx;
    logic [IW-1:0]  rd_addr;

    logic [VB-1:0]  r_inf_mem   [TARGETS];
    logic [VB-1:0]  r_held_mem  [TARGETS];
    logic [VB-1:0]  r_start_mem [TARGETS];
    logic [VB-1:0]  r_minu_mem  [TARGETS];
    logic [TARGETS-1:0] r_vld;

    logic [VB-1:0]  r_rd_inf, r_rd_held, r_rd_start, r_rd_minu;
    logic           r_rd_vld;

    logic [VB-1:0]  inf, held, st, mu, amt, now, used;
    logic [VB:0]    sum_inf, sum_held, ttl_edge;
    logic [VB-1:0]  add_inf, add_held, sub_inf;
    logic [VB-1:0]  w_inf, w_held, w_start, w_minu;
    logic           mem_we, rep_flag, expired;

    logic                 r_strobe, n_strobe;
    logic                 r_flag, n_flag;
    logic                 r_last, n_last;
    logic [TGT_W-1:0]     r_tgt, n_tgt;
    logic [FIELD_W-1:0]   r_o_inf, n_o_inf;
    logic [FIELD_W-1:0]   r_o_held, n_o_held;
    logic [FIELD_W-1:0]   r_o_start, n_o_start;
    logic [FIELD_W-1:0]   r_o_minu, n_o_minu;

    // Record fields; an entry never written reads as an absent record.
    assign inf  = r_rd_vld ? r_rd_inf   : '0;
    assign held = r_rd_vld ? r_rd_held  : '0;
    assign st   = r_rd_vld ? r_rd_start : '0;
    assign mu   = r_rd_vld ? r_rd_minu  : '0;
    assign amt  = VB'(r_cur.amount);
    assign now  = VB'(r_cur.now);
    assign used = VB'(r_cur.used);

    assign sum_inf  = {1'b0, inf} + {1'b0, amt};
    assign sum_held = {1'b0, held} + {1'b0, amt};
    assign add_inf  = sum_inf[VB]  ? '1 : sum_inf[VB-1:0];
    assign add_held = sum_held[VB] ? '1 : sum_held[VB-1:0];
    assign sub_inf  = (inf > amt) ? inf - amt : '0;
    assign rep_flag = (held != '0) && (now > st) && (used >= mu);
    // now - start > ttl with now > start is the same as now > start + ttl.
    assign ttl_edge = {1'b0, st} + {1'b0, i_ttl};
    assign expired  = (held != '0) && ({1'b0, now} > ttl_edge);

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        w_inf    = inf;
        w_held   = held;
        w_start  = st;
        w_minu   = mu;
        mem_we   = 1'b0;
        unique case (r_cur.kind)
            K_ADD: begin
                w_inf  = add_inf;
                mem_we = 1'b1;
            end
            K_SUB: begin
                w_inf  = sub_inf;
                mem_we = 1'b1;
                if (sub_inf == '0) begin
                    w_held  = '0;
                    w_start = '0;
                    w_minu  = '0;
                end
            end
            K_HOLD: begin
                w_held  = add_held;
                w_start = (now > st) ? now : st;
                w_minu  = (used > mu) ? used : mu;
                mem_we  = 1'b1;
            end
            K_RELEASE: begin
                w_inf   = sub_inf;
                w_held  = '0;
                w_start = '0;
                w_minu  = '0;
                mem_we  = 1'b1;
            end
            K_NULL: begin
                w_inf   = '0;
                w_held  = '0;
                w_start = '0;
                w_minu  = '0;
            end
            default: begin
            end
        endcase
        if (r_state != S_EXEC) begin
            mem_we = 1'b0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_idx     = r_idx;
        rd_addr   = r_idx;
        n_strobe  = 1'b0;
        n_flag    = 1'b0;
        n_last    = 1'b0;
        n_tgt     = r_tgt;
        n_o_inf   = r_o_inf;
        n_o_held  = r_o_held;
        n_o_start = r_o_start;
        n_o_minu  = r_o_minu;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = (i_item.kind == K_SCAN) ? '0 : IW'(i_item.target);
                if (!i_empty) begin
                    n_cur   = i_item;
                    n_idx   = rd_addr;
                    n_state = (i_item.kind == K_SCAN) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                n_strobe  = 1'b1;
                n_last    = 1'b1;
                n_flag    = (r_cur.kind == K_REPORT) && rep_flag;
                n_tgt     = r_cur.target;
                n_o_inf   = FIELD_W'(w_inf);
                n_o_held  = FIELD_W'(w_held);
                n_o_start = FIELD_W'(w_start);
                n_o_minu  = FIELD_W'(w_minu);
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                // Check the entry just read and fetch the next one.
                rd_addr = r_idx + IW'(1);
                n_idx   = rd_addr;
                if (expired) begin
                    n_strobe  = 1'b1;
                    n_flag    = 1'b1;
                    n_tgt     = TGT_W'(r_idx);
                    n_o_inf   = FIELD_W'(inf);
                    n_o_held  = FIELD_W'(held);
                    n_o_start = FIELD_W'(st);
                    n_o_minu  = FIELD_W'(mu);
                end
                if (r_idx == IW'(TARGETS-1)) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                n_strobe  = 1'b1;
                n_last    = 1'b1;
                n_tgt     = '0;
                n_o_inf   = '0;
                n_o_held  = '0;
                n_o_start = '0;
                n_o_minu  = '0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_strobe <= 1'b0;
            r_flag   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_flag   <= n_flag;
            r_last   <= n_last;
            if (mem_we) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_idx     <= n_idx;
        r_tgt     <= n_tgt;
        r_o_inf   <= n_o_inf;
        r_o_held  <= n_o_held;
        r_o_start <= n_o_start;
        r_o_minu  <= n_o_minu;
    end

    // Record memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_inf_mem[r_idx]   <= w_inf;
            r_held_mem[r_idx]  <= w_held;
            r_start_mem[r_idx] <= w_start;
            r_minu_mem[r_idx]  <= w_minu;
        end
        r_rd_inf   <= r_inf_mem[rd_addr];
        r_rd_held  <= r_held_mem[rd_addr];
        r_rd_start <= r_start_mem[rd_addr];
        r_rd_minu  <= r_minu_mem[rd_addr];
        r_rd_vld   <= r_vld[rd_addr];
    end

    assign o_strobe        = r_strobe;
    assign o_flag          = r_flag;
    assign o_last          = r_last;
    assign o_result_target = r_tgt;
    assign o_inflight_now  = r_o_inf;
    assign o_held_now      = r_o_held;
    assign o_hold_start_ms = r_o_start;
    assign o_min_used_now  = r_o_minu;

endmodule

FILE: hdl/ihct_check.sv
// Port-level checks for the credit tracker, bound to the top level.
// Depends only on the ports of inflight_hold_credit_tracker.
`timescale 1ns / 1ps

module ihct_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_strobe,
    input logic o_flag,
    input logic o_last
);

    // Reset leaves no result on the port and the queue open.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("result or busy right after reset");

    // Only scan hits are non-final, and every scan hit is flagged.
    a_scan_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_flag)
        else $error("non-final result without expired flag");

    // Flag and last carry nothing between results.
    a_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_flag && !o_last)
        else $error("flag or last without strobe");

    // Every command passes through idle before its next result, so a final
    // result is always followed by a quiet cycle.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result right after a final result");

endmodule

bind inflight_hold_credit_tracker ihct_check u_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_flag   (o_flag),
    .o_last   (o_last)
);

FILE: dv/tb_top.sv
// Testbench for inflight_hold_credit_tracker: directed and random commands checked against a
// shadow copy of the credit records, with TTL changes between phases and a cycle watchdog.
// Depends on ihct_pkg and the inflight_hold_credit_tracker top level.
`timescale 1ns / 1ps

module tb_top;
    import ihct_pkg::*;

    localparam logic [OPC_W-1:0] OPC_SPARE = 3'd7;    // unassigned code, acts as a query
    localparam int NUM_TGT = TARGETS_DEF;
    localparam logic [FIELD_W-1:0] VMAX = {FIELD_W{1'b1}};
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 2 * NUM_TGT + 8;
    localparam int PHASE_ITEMS = 30;

    typedef struct packed {
        logic [TGT_W-1:0]   tgt;
        logic [FIELD_W-1:0] inflight;
        logic [FIELD_W-1:0] held;
        logic [FIELD_W-1:0] hstart;
        logic [FIELD_W-1:0] min_used;
        logic               flag;
        logic               last;
    } t_record;

    class credit_ledger;
        logic [FIELD_W-1:0] inflight [NUM_TGT];
        logic [FIELD_W-1:0] held [NUM_TGT];
        logic [FIELD_W-1:0] hstart [NUM_TGT];
        logic [FIELD_W-1:0] min_used [NUM_TGT];
        logic [FIELD_W-1:0] ttl;
        t_record            pending_records [$];
        int                 errors;

        function new();
            ttl = TTL_RESET;
            errors = 0;
            for (int i = 0; i < NUM_TGT; i++) clear_entry(i);
        endfunction

        function void clear_entry(int t);
            inflight[t] = '0;
            held[t] = '0;
            hstart[t] = '0;
            min_used[t] = '0;
        endfunction

        function logic [FIELD_W-1:0] sat_sum(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
            logic [FIELD_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[FIELD_W] ? VMAX : s[FIELD_W-1:0];
        endfunction

        // Floor at zero; an empty in-flight count drops the whole record.
        function void drop_inflight(int t, logic [FIELD_W-1:0] amt);
            if (inflight[t] > amt) inflight[t] = inflight[t] - amt;
            else clear_entry(t);
        endfunction

        function void push_entry(int t, logic flag, logic last);
            t_record rec;
            rec.tgt = t[TGT_W-1:0];
            rec.inflight = inflight[t];
            rec.held = held[t];
            rec.hstart = hstart[t];
            rec.min_used = min_used[t];
            rec.flag = flag;
            rec.last = last;
            pending_records.push_back(rec);
        endfunction

        function void note_command(input logic [OPC_W-1:0] op, input logic [TGT_W-1:0] tgt,
                                   input logic [FIELD_W-1:0] amt, now, used);
            t_record closing;
            logic    flag;
            int      t;
            t = tgt;
            flag = 1'b0;
            if (op == OPC_SCAN) begin
                for (int i = 0; i < NUM_TGT; i++) begin
                    if (held[i] != 0 && now > hstart[i] && (now - hstart[i]) > ttl)
                        push_entry(i, 1'b1, 1'b0);
                end
                closing = '0;
                closing.last = 1'b1;
                pending_records.push_back(closing);
            end else begin
                case (op)
                    OPC_ADD: begin
                        inflight[t] = sat_sum(inflight[t], amt);
                    end
                    OPC_SUB: begin
                        drop_inflight(t, amt);
                    end
                    OPC_HOLD: begin
                        held[t] = sat_sum(held[t], amt);
                        if (now > hstart[t]) hstart[t] = now;
                        if (used > min_used[t]) min_used[t] = used;
                    end
                    OPC_RELEASE: begin
                        drop_inflight(t, amt);
                        held[t] = '0;
                        hstart[t] = '0;
                        min_used[t] = '0;
                    end
                    OPC_REPORT: begin
                        flag = (held[t] != 0 && now > hstart[t] && used >= min_used[t]);
                    end
                    default: begin
                    end
                endcase
                push_entry(t, flag, 1'b1);
            end
        endfunction

        function void compare(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_record(t_record got);
            t_record want;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual target %0d last %0b",
                         $time, got.tgt, got.last);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            compare("result_target", FIELD_W'(want.tgt), FIELD_W'(got.tgt));
            compare("inflight_now", want.inflight, got.inflight);
            compare("held_now", want.held, got.held);
            compare("hold_start_ms", want.hstart, got.hstart);
            compare("min_used_now", want.min_used, got.min_used);
            compare("flag", FIELD_W'(want.flag), FIELD_W'(got.flag));
            compare("last", FIELD_W'(want.last), FIELD_W'(got.last));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OPC_W-1:0]   i_opcode = OPC_QUERY;
    logic [TGT_W-1:0]   i_target = '0;
    logic [FIELD_W-1:0] i_amount_bytes = '0;
    logic [FIELD_W-1:0] i_time_ms = '0;
    logic [FIELD_W-1:0] i_used_memory = '0;
    logic               i_cfg_we = 1'b0;
    logic [FIELD_W-1:0] i_cfg_wdata = '0;
    logic               o_strobe;
    logic [TGT_W-1:0]   o_result_target;
    logic [FIELD_W-1:0] o_inflight_now;
    logic [FIELD_W-1:0] o_held_now;
    logic [FIELD_W-1:0] o_hold_start_ms;
    logic [FIELD_W-1:0] o_min_used_now;
    logic               o_flag;
    logic               o_last;

    credit_ledger       ledger;
    t_record            seen;
    int                 idle_cycles = 0;
    bit                 no_idle = 1'b0;
    logic [FIELD_W-1:0] clock_ms;

    inflight_hold_credit_tracker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_target        (i_target),
        .i_amount_bytes  (i_amount_bytes),
        .i_time_ms       (i_time_ms),
        .i_used_memory   (i_used_memory),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_result_target (o_result_target),
        .o_inflight_now  (o_inflight_now),
        .o_held_now      (o_held_now),
        .o_hold_start_ms (o_hold_start_ms),
        .o_min_used_now  (o_min_used_now),
        .o_flag          (o_flag),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample both sides on the edge that accepts them; also run the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                ledger.note_command(i_opcode, i_target, i_amount_bytes, i_time_ms,
                                    i_used_memory);
            end
            if (o_strobe) begin
                seen.tgt = o_result_target;
                seen.inflight = o_inflight_now;
                seen.held = o_held_now;
                seen.hstart = o_hold_start_ms;
                seen.min_used = o_min_used_now;
                seen.flag = o_flag;
                seen.last = o_last;
                ledger.check_record(seen);
            end
        end
        if ((start && !busy) || o_strobe) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VMAX;
            2, 3: return rand48();
            4: return VMAX - FIELD_W'($urandom_range(0, 1000));
            default: return FIELD_W'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_time();
        case ($urandom_range(0, 19))
            0: return rand48();
            1: return VMAX;
            2: return '0;
            default: return clock_ms;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Call just after a rising edge; returns just after the edge that accepted the transaction,
    // plus a random idle stretch.
    task automatic issue(input logic [OPC_W-1:0] op, input logic [TGT_W-1:0] tgt,
                         input logic [FIELD_W-1:0] amt, now, used);
        int gap;
        start <= 1'b1;
        i_opcode <= op;
        i_target <= tgt;
        i_amount_bytes <= amt;
        i_time_ms <= now;
        i_used_memory <= used;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off new commands until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (ledger.pending_records.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_ttl(input logic [FIELD_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.ttl = value;
        @(posedge i_clk);
    endtask

    task automatic random_command();
        logic [OPC_W-1:0]   op;
        logic [TGT_W-1:0]   tgt;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 22) op = OPC_ADD;
        else if (r < 34) op = OPC_SUB;
        else if (r < 52) op = OPC_HOLD;
        else if (r < 62) op = OPC_RELEASE;
        else if (r < 78) op = OPC_REPORT;
        else if (r < 88) op = OPC_SCAN;
        else if (r < 95) op = OPC_QUERY;
        else op = OPC_SPARE;
        // Mostly a few hot targets so records build up; sometimes any target.
        if ($urandom_range(0, 3) == 0) tgt = TGT_W'($urandom_range(0, NUM_TGT - 1));
        else tgt = TGT_W'($urandom_range(0, 3));
        clock_ms = clock_ms + FIELD_W'($urandom_range(0, 3000));
        issue(op, tgt, pick_value(), pick_time(), pick_value());
    endtask

    initial begin
        logic [FIELD_W-1:0] ttl_val;
        ledger = new();
        clock_ms = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part, reset TTL of 60000 ms.
        issue(OPC_QUERY, 4'd0, '0, '0, '0);
        issue(OPC_ADD, 4'd3, VMAX, '0, '0);
        issue(OPC_ADD, 4'd3, 48'd5, '0, '0);                 // saturates
        issue(OPC_HOLD, 4'd3, 48'd100, 48'd1000, 48'd500);
        issue(OPC_HOLD, 4'd3, VMAX, 48'd500, 48'd200);       // keep later start, larger min
        issue(OPC_REPORT, 4'd3, '0, 48'd1000, 48'd500);      // time not after start
        issue(OPC_REPORT, 4'd3, '0, 48'd1001, 48'd499);      // usage below minimum
        issue(OPC_REPORT, 4'd3, '0, 48'd1001, 48'd500);      // releasable
        issue(OPC_SCAN, 4'd0, '0, 48'd61000, '0);            // age equal to TTL
        issue(OPC_SCAN, 4'd9, '0, 48'd61001, '0);            // just past TTL
        issue(OPC_RELEASE, 4'd3, 48'd1, '0, '0);
        issue(OPC_REPORT, 4'd3, '0, 48'd5000, '0);           // no hold left
        issue(OPC_SUB, 4'd3, VMAX, '0, '0);                  // floor at zero
        issue(OPC_ADD, 4'd5, 48'd10, '0, '0);
        issue(OPC_HOLD, 4'd5, '0, VMAX, VMAX);               // zero-byte hold
        issue(OPC_SCAN, 4'd5, '0, VMAX, '0);
        issue(OPC_SUB, 4'd5, 48'd3, '0, '0);
        issue(OPC_HOLD, 4'd5, 48'd7, 48'd20, '0);
        issue(OPC_SUB, 4'd5, 48'd7, '0, '0);                 // exactly zero clears record
        issue(OPC_SPARE, 4'd15, VMAX, VMAX, VMAX);
        issue(OPC_QUERY, 4'd15, VMAX, VMAX, VMAX);
        issue(OPC_RELEASE, 4'd7, VMAX, '0, '0);              // absent record
        issue(OPC_ADD, 4'd7, VMAX, '0, '0);
        issue(OPC_SUB, 4'd7, '0, '0, '0);
        issue(OPC_SCAN, 4'd15, VMAX, '0, VMAX);
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: ttl_val = '0;
                1: ttl_val = VMAX;
                2: ttl_val = FIELD_W'($urandom_range(500, 5000));
                3: ttl_val = TTL_RESET;
                default: ttl_val = FIELD_W'($urandom_range(1, 3));
            endcase
            set_ttl(ttl_val);
            no_idle = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_command();
                if (p == 2 && k == PHASE_ITEMS / 2) drain();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending_records.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
